// ===== rtl/core/pscp_pkg.sv =====
// shared types and constants for the periodic schedule min-cost route search
package pscp_pkg;

	localparam int PRICE_W  = 16;
	localparam int PERIOD_W = 6;
	localparam int SLOT_W   = 5;
	localparam int CITY_W   = 4;
	localparam int COST_W   = 32;
	localparam int CCNT_W   = 5;
	localparam int DCNT_W   = 11;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 11;

	localparam logic [COST_W-1:0] COST_INF = 32'hFFFF_FFFF;
	localparam logic [COST_W-1:0] COST_SAT = 32'hFFFF_FFFE;

	localparam logic [CIDX_W-1:0] REG_CITY_COUNT = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DAY_COUNT  = 2'd1;

	typedef enum logic [1:0] {
		KIND_PRICE  = 2'd0,
		KIND_PERIOD = 2'd1,
		KIND_RUN    = 2'd2
	} kind_t;

	typedef struct packed {
		logic first_day;
		logic a_first;
		logic a_last;
		logic last_step;
	} step_flags_t;

endpackage

// ===== rtl/core/pscp_engine.sv =====
// memory pipeline: price, period, phase and cost memories with per-step relaxation
module pscp_engine #(
	parameter int MAX_CITIES = 16,
	parameter int MAX_PERIOD = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic price_we,
	input  logic period_we,
	input  logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0] ld_pair,
	input  logic [((MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1)-1:0] ld_slot,
	input  logic [pscp_pkg::PRICE_W-1:0] ld_price,
	input  logic [pscp_pkg::PERIOD_W-1:0] ld_period,
	input  logic issue_valid,
	input  logic [$clog2(MAX_CITIES)-1:0] issue_a,
	input  logic [$clog2(MAX_CITIES)-1:0] issue_b,
	input  logic issue_parity,
	input  pscp_pkg::step_flags_t issue_flags,
	output logic res_valid,
	output logic [pscp_pkg::COST_W-1:0] res_cost
);
	import pscp_pkg::*;

	localparam int CW       = $clog2(MAX_CITIES);
	localparam int PAIRS    = MAX_CITIES * MAX_CITIES;
	localparam int PAIR_AW  = $clog2(PAIRS);
	localparam int PHW      = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
	localparam int PERW     = $clog2(MAX_PERIOD + 1);
	localparam int PRICES   = PAIRS * MAX_PERIOD;
	localparam int PRICE_AW = (PRICES > 1) ? $clog2(PRICES) : 1;
	localparam int COSTS    = 2 * MAX_CITIES;
	localparam int COST_AW  = $clog2(COSTS);

	logic [PRICE_W-1:0]  price_mem  [PRICES];
	logic [PERIOD_W-1:0] period_mem [PAIRS];
	logic [PHW-1:0]      phase_mem  [PAIRS];
	logic [COST_W-1:0]   cost_mem   [COSTS];

	logic [PAIR_AW-1:0]  issue_pair;
	logic [COST_AW-1:0]  cost_raddr;
	logic [PRICE_AW-1:0] price_waddr;
	logic [PRICE_AW-1:0] price_raddr;

	logic [PRICE_W-1:0]  price_rd;
	logic [PERIOD_W-1:0] period_rd;
	logic [PHW-1:0]      phase_rd;
	logic [COST_W-1:0]   cost_rd;

	logic                valid_s1;
	logic [CW-1:0]       a_s1;
	logic [CW-1:0]       b_s1;
	logic [PAIR_AW-1:0]  pair_s1;
	logic                parity_s1;
	step_flags_t         flags_s1;

	logic [PERW-1:0]     per_eff;
	logic [PHW-1:0]      phase_cur;
	logic [PHW-1:0]      phase_nx;
	logic [COST_W-1:0]   base;
	logic                link_ok;

	logic                valid_s2;
	logic [CW-1:0]       b_s2;
	logic                parity_s2;
	step_flags_t         flags_s2;
	logic [COST_W-1:0]   base_s2;
	logic                link_s2;

	logic [COST_W:0]     sum;
	logic [COST_W-1:0]   cand;
	logic [COST_W-1:0]   acc_in;
	logic [COST_W-1:0]   acc_nx;
	logic [COST_W-1:0]   acc_q;
	logic [COST_AW-1:0]  cost_waddr;

	assign issue_pair  = PAIR_AW'(int'(issue_a) * MAX_CITIES + int'(issue_b));
	assign cost_raddr  = COST_AW'(int'(issue_parity) * MAX_CITIES + int'(issue_a));
	assign price_waddr = PRICE_AW'(int'(ld_pair) * MAX_PERIOD + int'(ld_slot));

	// stage 1: period clamp, phase of this pair on this day, base cost
	always_comb begin
		if (int'(period_rd) > MAX_PERIOD) begin
			per_eff = PERW'(MAX_PERIOD);
		end else begin
			per_eff = PERW'(period_rd);
		end
		phase_cur = flags_s1.first_day ? '0 : phase_rd;
		if (int'(phase_cur) + 1 >= int'(per_eff)) begin
			phase_nx = '0;
		end else begin
			phase_nx = phase_cur + 1'b1;
		end
		if (flags_s1.first_day) begin
			base = (a_s1 == '0) ? '0 : COST_INF;
		end else begin
			base = cost_rd;
		end
		link_ok     = (period_rd != '0) && (a_s1 != b_s1) && (base != COST_INF);
		price_raddr = PRICE_AW'(int'(pair_s1) * MAX_PERIOD + int'(phase_cur));
	end

	// stage 2: saturating add and running minimum over sources
	always_comb begin
		sum = {1'b0, base_s2} + (COST_W + 1)'(price_rd);
		if (link_s2 && (price_rd != '0)) begin
			cand = (sum > {1'b0, COST_SAT}) ? COST_SAT : sum[COST_W-1:0];
		end else begin
			cand = COST_INF;
		end
		acc_in     = flags_s2.a_first ? COST_INF : acc_q;
		acc_nx     = (cand < acc_in) ? cand : acc_in;
		cost_waddr = COST_AW'((parity_s2 ? 0 : MAX_CITIES) + int'(b_s2));
	end

	always_ff @(posedge clk) begin
		if (price_we) begin
			price_mem[price_waddr] <= ld_price;
		end
		price_rd <= price_mem[price_raddr];
	end

	always_ff @(posedge clk) begin
		if (period_we) begin
			period_mem[ld_pair] <= ld_period;
		end
		period_rd <= period_mem[issue_pair];
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			phase_mem[pair_s1] <= phase_nx;
		end
		phase_rd <= phase_mem[issue_pair];
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && flags_s2.a_last) begin
			cost_mem[cost_waddr] <= acc_nx;
		end
		cost_rd <= cost_mem[cost_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			valid_s1  <= issue_valid;
			valid_s2  <= valid_s1;
			res_valid <= valid_s2 && flags_s2.last_step;
		end
	end

	always_ff @(posedge clk) begin
		a_s1      <= issue_a;
		b_s1      <= issue_b;
		pair_s1   <= issue_pair;
		parity_s1 <= issue_parity;
		flags_s1  <= issue_flags;
		b_s2      <= b_s1;
		parity_s2 <= parity_s1;
		flags_s2  <= flags_s1;
		base_s2   <= base;
		link_s2   <= link_ok;
		if (valid_s2) begin
			acc_q <= acc_nx;
		end
		if (valid_s2 && flags_s2.last_step) begin
			res_cost <= acc_nx;
		end
	end

endmodule

// ===== rtl/core/periodic_schedule_min_cost_path.sv =====
// top level: request decode, configuration registers, run sequencer and result register
//
// Price and period load requests are written into the engine memories on acceptance. A run
// request walks every (day, destination, source) triple through the engine's memory
// pipeline, one triple per cycle within a day, with an idle gap between days so the
// new cost row is written before it is read. No request is taken during a run;
// configuration writes are taken at any time. The result waits in an output register,
// and loads are still taken while it waits.
module periodic_schedule_min_cost_path #(
	parameter int MAX_CITIES = 16,
	parameter int MAX_PERIOD = 32,
	parameter int MAX_DAYS   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // from_city, to_city, slot, price, period, zero pad
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // best_cost
	output logic        m_tuser,   // found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pscp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [pscp_pkg::CDATA_W-1:0] cfg_data
);
	import pscp_pkg::*;

	localparam int CW      = $clog2(MAX_CITIES);
	localparam int PAIR_AW = $clog2(MAX_CITIES * MAX_CITIES);
	localparam int PHW     = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
	localparam int DW      = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_GAP,
		ST_WAIT,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [CCNT_W-1:0]    city_count_q;
	logic [DCNT_W-1:0]    day_count_q;
	logic [CW-1:0]        a_q;
	logic [CW-1:0]        b_q;
	logic [DW-1:0]        d_q;
	logic [CW-1:0]        n_last_q;
	logic [DW-1:0]        d_last_q;
	logic                 parity_q;
	logic                 first_q;
	logic                 gap_q;
	logic [COST_W-1:0]    res_cost_q;
	logic                 res_found_q;
	logic                 m_tvalid_q;
	logic [COST_W-1:0]    m_tdata_q;
	logic                 m_tuser_q;

	logic                 s_accept;
	kind_t                kind;
	logic [CITY_W-1:0]    from_city;
	logic [CITY_W-1:0]    to_city;
	logic [SLOT_W-1:0]    slot;
	logic [PRICE_W-1:0]   price;
	logic [PERIOD_W-1:0]  period;
	logic                 pair_ok;
	logic                 slot_ok;
	logic                 price_we;
	logic                 period_we;
	logic [PAIR_AW-1:0]   ld_pair;
	logic [PHW-1:0]       ld_slot;
	logic [CW-1:0]        n_last;
	logic [DW-1:0]        d_last;
	int                   n_eff;
	int                   days_eff;
	logic                 issue_valid;
	step_flags_t          issue_flags;
	logic                 res_valid;
	logic [COST_W-1:0]    res_cost;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign s_accept  = s_tvalid && s_tready;
	assign kind      = kind_t'(s_tuser);
	assign from_city = s_tdata[3:0];
	assign to_city   = s_tdata[7:4];
	assign slot      = s_tdata[12:8];
	assign price     = s_tdata[28:13];
	assign period    = s_tdata[34:29];

	always_comb begin
		pair_ok   = (int'(from_city) < MAX_CITIES) && (int'(to_city) < MAX_CITIES);
		slot_ok   = int'(slot) < MAX_PERIOD;
		price_we  = s_accept && (kind == KIND_PRICE) && pair_ok && slot_ok;
		period_we = s_accept && (kind == KIND_PERIOD) && pair_ok;
		ld_pair   = PAIR_AW'(int'(from_city) * MAX_CITIES + int'(to_city));
		ld_slot   = PHW'(slot);

		n_eff = int'(city_count_q);
		if (n_eff < 2) begin
			n_eff = 2;
		end else if (n_eff > MAX_CITIES) begin
			n_eff = MAX_CITIES;
		end
		days_eff = int'(day_count_q);
		if (days_eff < 1) begin
			days_eff = 1;
		end else if (days_eff > MAX_DAYS) begin
			days_eff = MAX_DAYS;
		end
		n_last = CW'(n_eff - 1);
		d_last = DW'(days_eff - 1);

		issue_valid           = (state_q == ST_RUN);
		issue_flags.first_day = first_q;
		issue_flags.a_first   = (a_q == '0);
		issue_flags.a_last    = (a_q == n_last_q);
		issue_flags.last_step = (d_q == d_last_q) && (b_q == n_last_q) && (a_q == n_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			city_count_q <= CCNT_W'(2);
			day_count_q  <= DCNT_W'(1);
			a_q          <= '0;
			b_q          <= '0;
			d_q          <= '0;
			n_last_q     <= '0;
			d_last_q     <= '0;
			parity_q     <= 1'b0;
			first_q      <= 1'b0;
			gap_q        <= 1'b0;
			res_cost_q   <= '0;
			res_found_q  <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_CITY_COUNT: city_count_q <= cfg_data[CCNT_W-1:0];
					REG_DAY_COUNT:  day_count_q  <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept && (kind == KIND_RUN)) begin
						a_q      <= '0;
						b_q      <= '0;
						d_q      <= '0;
						n_last_q <= n_last;
						d_last_q <= d_last;
						parity_q <= 1'b0;
						first_q  <= 1'b1;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (a_q == n_last_q) begin
						a_q <= '0;
						if (b_q == n_last_q) begin
							b_q <= '0;
							if (d_q == d_last_q) begin
								state_q <= ST_WAIT;
							end else begin
								d_q      <= d_q + 1'b1;
								parity_q <= ~parity_q;
								first_q  <= 1'b0;
								gap_q    <= 1'b0;
								state_q  <= ST_GAP;
							end
						end else begin
							b_q <= b_q + 1'b1;
						end
					end else begin
						a_q <= a_q + 1'b1;
					end
				end
				ST_GAP: begin
					gap_q <= 1'b1;
					if (gap_q) begin
						state_q <= ST_RUN;
					end
				end
				ST_WAIT: begin
					if (res_valid) begin
						res_cost_q  <= res_cost;
						res_found_q <= (res_cost != COST_INF);
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_found_q ? res_cost_q : '0;
						m_tuser_q  <= res_found_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	pscp_engine #(
		.MAX_CITIES (MAX_CITIES),
		.MAX_PERIOD (MAX_PERIOD)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.price_we     (price_we),
		.period_we    (period_we),
		.ld_pair      (ld_pair),
		.ld_slot      (ld_slot),
		.ld_price     (price),
		.ld_period    (period),
		.issue_valid  (issue_valid),
		.issue_a      (a_q),
		.issue_b      (b_q),
		.issue_parity (parity_q),
		.issue_flags  (issue_flags),
		.res_valid    (res_valid),
		.res_cost     (res_cost)
	);

endmodule
